/* hw/rtl/mme_pkg.sv */
package mme_pkg;

  // Store geometry and element width.
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PROD_W  = 2 * ELEM_WIDTH;
  localparam int SUM_W   = 40;

  // Field widths fixed by the interface.
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 3;
  localparam int VALUE_W = 16;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_WR_A   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              first;
    logic              term_end;
    logic [IDX_W-1:0]  row_i;
    logic [IDX_W-1:0]  col_j;
    logic              last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic res_taken;
  } sts_t;

endpackage

/* hw/rtl/matrix_multiply_engine.sv */
// Element writes (A or B) can arrive back to back.
// A compute transaction emits rows_m * cols_n results, with the dimensions clamped; each
// result is a multiply-accumulate over inner_k terms through one shared multiplier and
// the read and product registers into the accumulator; the next result starts once this one is taken.
// No input is taken while a compute run is in progress.
// Reset (rst, synchronous, active high) makes both stores read as zero and sets all dimensions to 8.
module matrix_multiply_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mme_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mme_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]     cfg_data
);
  import mme_pkg::*;

  // The controller walks the result elements in row-major order and, for
  // each one, issues inner_k store reads (A along the row, B down the
  // column). The datapath registers the reads, multiplies, and accumulates
  // exactly in 40 bits; the finished sum lands in the output register.
  // The controller holds the element's coordinates until that output
  // transaction completes, then moves to the next element.

  cmd_t cmd;
  sts_t sts;

  mme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stores clear through per-entry valid bits, so no clearing pass is needed.
  mme_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* hw/rtl/mme_dp.sv */
module mme_dp (
  input  logic               clk,
  input  logic               rst,
  input  mme_pkg::cmd_t      cmd,
  input  mme_pkg::in_item_t  in_item,
  output mme_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_stall,
  output mme_pkg::out_item_t out_item
);
  import mme_pkg::*;

  logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic [DEPTH-1:0]      a_vld;
  logic [DEPTH-1:0]      b_vld;

  logic signed [31:0]     value_ext;
  logic [ELEM_WIDTH-1:0]  wr_data;

  logic [ELEM_WIDTH-1:0]  a_raw;
  logic [ELEM_WIDTH-1:0]  b_raw;
  logic                   a_hit;
  logic                   b_hit;
  logic signed [ELEM_WIDTH-1:0] a_op;
  logic signed [ELEM_WIDTH-1:0] b_op;
  logic                   s1_vld;
  logic                   s1_first;
  logic                   s1_end;

  logic signed [PROD_W-1:0] prod;
  logic                   s2_vld;
  logic                   s2_first;
  logic                   s2_end;

  logic signed [SUM_W-1:0] prod_ext;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] acc_next;

  // Input value is sign-extended, then cut to the stored element width.
  assign value_ext = 32'(in_item.value);
  assign wr_data   = value_ext[ELEM_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_a) a_mem[cmd.wr_addr] <= wr_data;
    if (cmd.wr_b) b_mem[cmd.wr_addr] <= wr_data;
    a_raw <= a_mem[cmd.a_addr];
    b_raw <= b_mem[cmd.b_addr];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= '0;
      b_vld <= '0;
      a_hit <= 1'b0;
      b_hit <= 1'b0;
    end else begin
      if (cmd.wr_a) a_vld[cmd.wr_addr] <= 1'b1;
      if (cmd.wr_b) b_vld[cmd.wr_addr] <= 1'b1;
      a_hit <= a_vld[cmd.a_addr];
      b_hit <= b_vld[cmd.b_addr];
    end
  end

  assign a_op = a_hit ? $signed(a_raw) : '0;
  assign b_op = b_hit ? $signed(b_raw) : '0;

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s1_first <= 1'b0;
      s1_end   <= 1'b0;
      s2_vld   <= 1'b0;
      s2_first <= 1'b0;
      s2_end   <= 1'b0;
    end else begin
      s1_vld   <= cmd.rd_en;
      s1_first <= cmd.first;
      s1_end   <= cmd.term_end;
      s2_vld   <= s1_vld;
      s2_first <= s1_first;
      s2_end   <= s1_end;
    end
  end

  assign prod_ext = SUM_W'(prod);
  assign acc_next = s2_first ? prod_ext : SUM_W'(acc + prod_ext);

  always_ff @(posedge clk) begin
    if (s2_vld) acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_vld && s2_end) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Coordinates and last flag are held by the controller until the result is taken.
  always_ff @(posedge clk) begin
    if (s2_vld && s2_end) begin
      out_item.sum     <= acc_next;
      out_item.out_row <= POS_W'(cmd.row_i);
      out_item.out_col <= POS_W'(cmd.col_j);
      out_item.last    <= cmd.last;
    end
  end

  assign sts.res_taken = out_valid && !out_stall;

endmodule

/* hw/rtl/mme_ctrl.sv */
module mme_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mme_pkg::in_item_t           in_item,
  input  logic                        cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]   cfg_data,
  input  mme_pkg::sts_t               sts,
  output mme_pkg::cmd_t               cmd
);
  import mme_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] i_cnt;
  logic [IDX_W-1:0] i_cnt_next;
  logic [IDX_W-1:0] j_cnt;
  logic [IDX_W-1:0] j_cnt_next;
  logic [IDX_W-1:0] p_cnt;
  logic [IDX_W-1:0] p_cnt_next;
  logic [CFG_W-1:0] rows_m;
  logic [CFG_W-1:0] cols_n;
  logic [CFG_W-1:0] inner_k;

  logic [DIM_W-1:0] m_use;
  logic [DIM_W-1:0] n_use;
  logic [DIM_W-1:0] k_use;
  logic             in_acc;
  logic             wr_ok;
  logic             i_end;
  logic             j_end;
  logic             p_end;

  // Zero is used as one, anything above the store size as the store size.
  function automatic logic [DIM_W-1:0] dim_used(input logic [CFG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) d = DIM_W'(1);
    else if (32'(r) > MAX_DIM) d = DIM_W'(MAX_DIM);
    else d = DIM_W'(r);
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= CFG_W'(8);
      cols_n  <= CFG_W'(8);
      inner_k <= CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_M:  rows_m  <= cfg_data;
        CFG_COLS_N:  cols_n  <= cfg_data;
        CFG_INNER_K: inner_k <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m_use = dim_used(rows_m);
  assign n_use = dim_used(cols_n);
  assign k_use = dim_used(inner_k);

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_ok    = (32'(in_item.row) < MAX_DIM) && (32'(in_item.col) < MAX_DIM);

  assign i_end = (DIM_W'(i_cnt) + DIM_W'(1)) == m_use;
  assign j_end = (DIM_W'(j_cnt) + DIM_W'(1)) == n_use;
  assign p_end = (DIM_W'(p_cnt) + DIM_W'(1)) == k_use;

  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    j_cnt_next = j_cnt;
    p_cnt_next = p_cnt;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_item.func == FUNC_RUN) begin
          i_cnt_next = '0;
          j_cnt_next = '0;
          p_cnt_next = '0;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (p_end) begin
          p_cnt_next = '0;
          state_next = ST_WAIT;
        end else begin
          p_cnt_next = p_cnt + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (sts.res_taken) begin
          if (i_end && j_end) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ISSUE;
            if (j_end) begin
              j_cnt_next = '0;
              i_cnt_next = i_cnt + IDX_W'(1);
            end else begin
              j_cnt_next = j_cnt + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      p_cnt <= '0;
    end else begin
      state <= state_next;
      i_cnt <= i_cnt_next;
      j_cnt <= j_cnt_next;
      p_cnt <= p_cnt_next;
    end
  end

  always_comb begin
    cmd.wr_a     = in_acc && wr_ok && (in_item.func == FUNC_WR_A);
    cmd.wr_b     = in_acc && wr_ok && (in_item.func == FUNC_WR_B);
    cmd.wr_addr  = ADDR_W'(32'(in_item.row) * MAX_DIM + 32'(in_item.col));
    cmd.rd_en    = (state == ST_ISSUE);
    cmd.a_addr   = ADDR_W'(32'(i_cnt) * MAX_DIM + 32'(p_cnt));
    cmd.b_addr   = ADDR_W'(32'(p_cnt) * MAX_DIM + 32'(j_cnt));
    cmd.first    = (state == ST_ISSUE) && (p_cnt == '0);
    cmd.term_end = (state == ST_ISSUE) && p_end;
    cmd.row_i    = i_cnt;
    cmd.col_j    = j_cnt;
    cmd.last     = i_end && j_end;
  end

endmodule

/* hw/rtl/mme_chk.sv */
module mme_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input mme_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input mme_pkg::out_item_t out_item
);
  import mme_pkg::*;

  // No input is taken while a result is pending.
  a_no_input_during_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // A compute transaction locks the input side.
  a_run_locks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_item.func == FUNC_RUN) |=> in_stall)
    else $error("input not stalled after compute transaction");

  // The final result releases the input side.
  a_last_releases: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_item.last) |=> !in_stall)
    else $error("input still stalled after final result");

  // A taken result that is not final is not shown again the next cycle.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_item.last) |=> !out_valid)
    else $error("result repeated");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_engine mme_chk u_mme_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mme_pkg::*;

  // The block has no code for func value 3. Such a transaction must be swallowed silently.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // This margin covers the tail of a run and any write still in flight before the next
  // register write.
  localparam int DRAIN_CYCLES = 4 * (MAX_DIM + 3);
  // Even if every transaction were a full-size compute under the heaviest receiver stalls,
  // a correct run would need only a fraction of this.
  localparam int LIMIT_CYCLES = 2000000;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  matrix_multiply_engine uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's state. The register shadows hold the raw bits that were
  // written. Clamping to the usable range happens when a run is predicted or positions drawn.
  logic signed [VALUE_W-1:0] a_mem [MAX_DIM][MAX_DIM];
  logic signed [VALUE_W-1:0] b_mem [MAX_DIM][MAX_DIM];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  logic [CFG_W-1:0] inner_reg;

  // Elements of C that the block still owes, oldest first.
  out_item_t c_elems_due [$];

  int error_count    = 0;
  int items_sent     = 0;
  int runs_sent      = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  // The sender and the receiver read these to decide how they idle.
  stall_mode_t stall_mode   = STALL_RANDOM;
  int          gap_max      = 3;
  int          burst_left   = 0;
  int          hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A register value of 0 acts as 1, and anything above MAX_DIM acts as MAX_DIM.
  function automatic int used_dim(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  // The block emits rows_m * cols_n elements in row-major order. Each element is the
  // full-precision dot product over inner_k terms. All operands are signed, so the
  // 40-bit context sign-extends them before the multiply.
  task automatic compute_c_elems();
    int m;
    int n;
    int k;
    logic signed [SUM_W-1:0] acc;
    out_item_t e;
    m = used_dim(rows_reg);
    n = used_dim(cols_reg);
    k = used_dim(inner_reg);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int p = 0; p < k; p++) begin
          acc = acc + a_mem[i][p] * b_mem[p][j];
        end
        e.out_row = POS_W'(i);
        e.out_col = POS_W'(j);
        e.sum     = acc;
        e.last    = (i == m - 1) && (j == n - 1);
        c_elems_due.push_back(e);
      end
    end
  endtask

  // Updates the shadow state for one accepted input transaction.
  task automatic apply_item(input in_item_t it);
    case (it.func)
      FUNC_WR_A: begin
        if (it.row < MAX_DIM && it.col < MAX_DIM) a_mem[it.row][it.col] = it.value;
      end
      FUNC_WR_B: begin
        if (it.row < MAX_DIM && it.col < MAX_DIM) b_mem[it.row][it.col] = it.value;
      end
      FUNC_RUN: begin
        runs_sent++;
        compute_c_elems();
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(input logic [FUNC_W-1:0] f,
                                         input logic [POS_W-1:0] r,
                                         input logic [POS_W-1:0] c,
                                         input logic signed [VALUE_W-1:0] v);
    in_item_t it;
    it.func  = f;
    it.row   = r;
    it.col   = c;
    it.value = v;
    return it;
  endfunction

  // Element values lean toward the extremes. Those are where a sign or width slip shows.
  function automatic logic signed [VALUE_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return VALUE_W'(int'($urandom_range(0, 511)) - 256);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Most writes land inside the active region. Some land anywhere in the store, so that
  // contents outside the current dimensions are exercised too.
  function automatic logic [POS_W-1:0] pick_pos(input int lim);
    if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, MAX_DIM - 1));
    return POS_W'($urandom_range(0, lim - 1));
  endfunction

  // Offers one transaction and holds it until the block takes it. in_stall is read right
  // after the edge, before any nonblocking update, so it is the value the block saw.
  // On return in_valid is still high if no gap followed. The caller either offers the next
  // transaction in the same step or lowers valid. Bursts are split by random gaps.
  task automatic offer(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    apply_item(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && gap_max > 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // Waits until every owed result has come back, then lets the block settle so that
  // registers can be written safely.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (c_elems_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The extra edge keeps the lowering of cfg_we and the next write in separate steps.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROWS_M:  rows_reg  = data;
      CFG_COLS_N:  cols_reg  = data;
      CFG_INNER_K: inner_reg = data;
      default: ;
    endcase
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                          input logic [CFG_W-1:0] k);
    cfg_write(CFG_ROWS_M, m);
    cfg_write(CFG_COLS_N, n);
    cfg_write(CFG_INNER_K, k);
    settings_used++;
  endtask

  // A run straight out of reset must use 8 by 8 by 8 and see all-zero stores.
  task automatic test_reset_state();
    offer(make_item(FUNC_RUN, 3'd7, 3'd5, 16'sh7FFF));
    finish_phase();
  endtask

  // Eight products of the most negative element give the largest sum, 2^33. A second run
  // mixes the positive maximum into it. A transaction with the unused code sits in between,
  // and it must not disturb the stores.
  task automatic test_extreme_sum();
    set_dims(4'd1, 4'd1, 4'd8);
    for (int p = 0; p < MAX_DIM; p++) begin
      offer(make_item(FUNC_WR_A, 3'd0, POS_W'(p), 16'sh8000));
      offer(make_item(FUNC_WR_B, POS_W'(p), 3'd0, 16'sh8000));
    end
    offer(make_item(FUNC_RUN, 3'd0, 3'd0, '0));
    offer(make_item(FUNC_WR_A, 3'd0, 3'd0, 16'sh7FFF));
    offer(make_item(FUNC_UNUSED, 3'd0, 3'd0, 16'sh1234));
    offer(make_item(FUNC_RUN, 3'd0, 3'd0, '0));
    finish_phase();
  endtask

  // Register values of zero and above MAX_DIM must clamp. A write to the index past the
  // last register must be ignored.
  task automatic test_dim_clamp();
    offer(make_item(FUNC_WR_A, 3'd7, 3'd7, 16'sh8000));
    offer(make_item(FUNC_WR_B, 3'd7, 3'd7, 16'sh7FFF));
    finish_phase();
    set_dims(4'd0, 4'd15, 4'd9);
    cfg_write(CFG_IDX_W'(3), 4'hF);
    offer(make_item(FUNC_RUN, 3'd1, 3'd2, '0));
    finish_phase();
    set_dims(4'd9, 4'd0, 4'd0);
    offer(make_item(FUNC_RUN, 3'd6, 3'd3, '0));
    finish_phase();
  endtask

  // Random traffic under several dimension settings. Each phase mostly fills A and B in the
  // active region, runs a compute now and then, and adds a little noise with the unused
  // code. The idling of both sides changes from phase to phase. One phase runs flat out.
  task automatic test_random_mix();
    logic [CFG_W-1:0] rows_set [5] = '{4'd1, 4'd8, 4'd3, 4'd2, 4'd0};
    logic [CFG_W-1:0] cols_set [5] = '{4'd1, 4'd8, 4'd5, 4'd8, 4'd0};
    logic [CFG_W-1:0] inner_set [5] = '{4'd1, 4'd8, 4'd2, 4'd1, 4'd0};
    stall_mode_t modes [5] = '{STALL_NONE, STALL_RANDOM, STALL_BURSTY, STALL_RANDOM,
                               STALL_BURSTY};
    int gaps [5] = '{0, 4, 2, 8, 3};
    int m;
    int n;
    int k;
    int sel;
    in_item_t it;
    for (int ph = 0; ph < 5; ph++) begin
      // The last phase draws raw register values over the whole 4-bit range.
      if (ph == 4) begin
        set_dims(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                 CFG_W'($urandom_range(0, 15)));
      end else begin
        set_dims(rows_set[ph], cols_set[ph], inner_set[ph]);
      end
      stall_mode = modes[ph];
      gap_max    = gaps[ph];
      m = used_dim(rows_reg);
      n = used_dim(cols_reg);
      k = used_dim(inner_reg);
      for (int t = 0; t < 37; t++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          it = make_item(FUNC_WR_A, pick_pos(m), pick_pos(k), rand_elem());
        end else if (sel < 85) begin
          it = make_item(FUNC_WR_B, pick_pos(k), pick_pos(n), rand_elem());
        end else if (sel < 95) begin
          it = make_item(FUNC_RUN, POS_W'($urandom), POS_W'($urandom), VALUE_W'($urandom));
        end else begin
          it = make_item(FUNC_UNUSED, POS_W'($urandom), POS_W'($urandom),
                         VALUE_W'($urandom));
        end
        offer(it);
      end
      offer(make_item(FUNC_RUN, POS_W'($urandom), POS_W'($urandom), VALUE_W'($urandom)));
      finish_phase();
    end
  endtask

  // The receiver holds off for a long stretch while a full-size run is pending. The sender
  // keeps offering writes behind it, so the output backs up and the block must stall
  // its input. None of those writes may reach the stores before the run is done.
  task automatic test_backpressure();
    set_dims(4'd8, 4'd8, 4'd8);
    stall_mode   = STALL_RANDOM;
    gap_max      = 0;
    hold_request = 400;
    offer(make_item(FUNC_RUN, '0, '0, '0));
    for (int t = 0; t < 12; t++) begin
      offer(make_item($urandom_range(0, 1) ? FUNC_WR_A : FUNC_WR_B,
                      POS_W'($urandom), POS_W'($urandom), rand_elem()));
    end
    offer(make_item(FUNC_RUN, '0, '0, '0));
    finish_phase();
  endtask

  // Receiver. It keeps its own stall pattern, and a requested hold-off overrides it.
  // The hold-off is counted here in cycles.
  initial begin : receiver
    int  hold_n;
    int  run_left;
    logic run_stall;
    run_left  = 0;
    run_stall = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_n       = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (hold_n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 30);
          default: begin
            // Alternating runs of stall and flow, each of random length.
            if (run_left == 0) begin
              run_stall = !run_stall;
              run_left  = run_stall ? $urandom_range(1, 6) : $urandom_range(1, 10);
            end
            run_left--;
            out_stall <= run_stall;
          end
        endcase
      end
    end
  end

  // Compares each result transaction with the oldest owed element of C, field by field.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (c_elems_due.size() == 0) begin
        $error("unexpected result: out_row %0d out_col %0d sum %0d last %0b",
               out_item.out_row, out_item.out_col, out_item.sum, out_item.last);
        error_count++;
      end else begin
        want = c_elems_due.pop_front();
        if (out_item.out_row !== want.out_row) begin
          $error("out_row mismatch: expected %0d, actual %0d", want.out_row, out_item.out_row);
          error_count++;
        end
        if (out_item.out_col !== want.out_col) begin
          $error("out_col mismatch: expected %0d, actual %0d", want.out_col, out_item.out_col);
          error_count++;
        end
        if (out_item.sum !== want.sum) begin
          $error("sum mismatch: expected %0d, actual %0d", want.sum, out_item.sum);
          error_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $error("run exceeded %0d cycles, %0d results still owed", LIMIT_CYCLES,
             c_elems_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      for (int j = 0; j < MAX_DIM; j++) begin
        a_mem[i][j] = '0;
        b_mem[i][j] = '0;
      end
    end
    rows_reg  = 4'd8;
    cols_reg  = 4'd8;
    inner_reg = 4'd8;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_extreme_sum();
    test_dim_clamp();
    test_random_mix();
    test_backpressure();

    if (c_elems_due.size() != 0) begin
      $error("%0d results never arrived", c_elems_due.size());
      error_count++;
    end
    $display("Sent %0d input transactions with %0d compute runs, checked %0d results, over %0d",
             items_sent, runs_sent, results_seen, settings_used);
    $display("dimension settings including clamped values, extreme elements and a long hold-off.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mme_pkg.sv
hw/rtl/mme_dp.sv
hw/rtl/mme_ctrl.sv
hw/rtl/matrix_multiply_engine.sv
hw/rtl/mme_chk.sv
tb/tb_top.sv
